[hw/rtl/llhs_pkg.sv]
// Shared constants, operation codes and state codes for the latency histogram block.
package llhs_pkg;

    // Field widths of the request and result ports
    localparam int OP_W      = 1;
    localparam int TIME_W    = 64;
    localparam int BYTES_W   = 32;
    localparam int PCT_W     = 14;
    localparam int BKT_OUT_W = 11;
    localparam int LAT_OUT_W = 23;
    localparam int CNT_OUT_W = 32;
    localparam int SUM_W     = 64;

    // Percentile scale: hundredths of a percent
    localparam int unsigned PCT_SCALE = 10000;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RECORD = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY  = 1'b1;

    // Controller state codes
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_CLEAR = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
    localparam logic [ST_W-1:0] ST_LAT   = 4'd2;
    localparam logic [ST_W-1:0] ST_BKT   = 4'd3;
    localparam logic [ST_W-1:0] ST_RMW   = 4'd4;
    localparam logic [ST_W-1:0] ST_THR   = 4'd5;
    localparam logic [ST_W-1:0] ST_WALK  = 4'd6;
    localparam logic [ST_W-1:0] ST_MID   = 4'd7;
    localparam logic [ST_W-1:0] ST_DONE  = 4'd8;

endpackage

[hw/rtl/llhs_bucket_mem.sv]
// Histogram bucket count memory: one write port, one read port, registered read data.
module llhs_bucket_mem #(
    parameter int DEPTH = 1152,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/llhs_bucket_index.sv]
// Two-stage bucket index unit: leading-one search, then octave and sub-bucket select.
module llhs_bucket_index #(
    parameter int SUB_BUCKETS = 64,
    parameter int OCTAVES     = 18
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_vld,
    input  logic [llhs_pkg::TIME_W-1:0]                         lat,
    output logic                                                out_vld,
    output logic [$clog2(SUB_BUCKETS*OCTAVES)-1:0]              idx
);
    import llhs_pkg::*;

    localparam int SUB_LOG = $clog2(SUB_BUCKETS);
    localparam int IDX_W   = $clog2(SUB_BUCKETS * OCTAVES);
    localparam int OCT_W   = IDX_W - SUB_LOG;
    localparam int LEN_W   = $clog2(TIME_W + 1);
    localparam int SAT_LEN = SUB_LOG + OCTAVES - 1;

    logic [LEN_W-1:0]   bitlen;
    logic [LEN_W-1:0]   halv_raw;
    logic [OCT_W-1:0]   halv;
    logic               sat;

    logic               s1_vld_reg;
    logic [TIME_W-1:0]  s1_lat_reg;
    logic [OCT_W-1:0]   s1_halv_reg;
    logic               s1_sat_reg;

    logic [TIME_W-1:0]  shifted;
    logic [SUB_LOG-1:0] sub;
    logic [IDX_W-1:0]   idx_next;
    logic               out_vld_reg;
    logic [IDX_W-1:0]   idx_reg;

    // Find the bit length of the latency
    always_comb
    begin
        bitlen = '0;
        for (int k = 0; k < TIME_W; k++)
        begin
            if (lat[k])
            begin
                bitlen = LEN_W'(k + 1);
            end
        end
    end

    // Count halvings, capped at the top octave
    always_comb
    begin
        if (bitlen > LEN_W'(SUB_LOG))
        begin
            halv_raw = bitlen - LEN_W'(SUB_LOG);
        end
        else
        begin
            halv_raw = '0;
        end
        if (halv_raw > LEN_W'(OCTAVES - 1))
        begin
            halv = OCT_W'(OCTAVES - 1);
        end
        else
        begin
            halv = halv_raw[OCT_W-1:0];
        end
        sat = (bitlen > LEN_W'(SAT_LEN));
    end

    // Hold stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lat_reg  <= lat;
        s1_halv_reg <= halv;
        s1_sat_reg  <= sat;
    end

    // Select the sub-bucket within the octave
    always_comb
    begin
        shifted = s1_lat_reg >> (s1_halv_reg - OCT_W'(1));
        if (s1_sat_reg)
        begin
            sub = '1;
        end
        else
        begin
            sub = shifted[SUB_LOG-1:0];
        end
        if (s1_halv_reg < OCT_W'(2))
        begin
            idx_next = s1_lat_reg[IDX_W-1:0];
        end
        else
        begin
            idx_next = {s1_halv_reg, sub};
        end
    end

    // Hold stage two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign out_vld = out_vld_reg;
    assign idx     = idx_reg;

endmodule

[hw/rtl/llhs_midpoint.sv]
// Registered bucket midpoint latency from a bucket index.
module llhs_midpoint #(
    parameter int SUB_BUCKETS = 64,
    parameter int OCTAVES     = 18
) (
    input  logic                                   clk,
    input  logic [$clog2(SUB_BUCKETS*OCTAVES)-1:0] idx,
    output logic [llhs_pkg::SUM_W-1:0]             mid
);
    import llhs_pkg::*;

    localparam int SUB_LOG = $clog2(SUB_BUCKETS);
    localparam int IDX_W   = $clog2(SUB_BUCKETS * OCTAVES);
    localparam int OCT_W   = IDX_W - SUB_LOG;

    logic [OCT_W-1:0]   oct;
    logic [SUB_LOG-1:0] sub;
    logic [OCT_W-1:0]   sh;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   mid_next;
    logic [SUM_W-1:0]   mid_reg;

    // Split the index, clamp past the top bucket, build the midpoint
    always_comb
    begin
        oct = idx[IDX_W-1:SUB_LOG];
        sub = idx[SUB_LOG-1:0];
        if (oct > OCT_W'(OCTAVES - 1))
        begin
            oct = OCT_W'(OCTAVES - 1);
            sub = '1;
        end
        sh   = oct - OCT_W'(1);
        base = SUM_W'(SUB_BUCKETS) + SUM_W'(sub);
        if (oct == '0)
        begin
            mid_next = SUM_W'(sub);
        end
        else
        begin
            mid_next = (base << sh) + ((SUM_W'(1) << sh) >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    assign mid = mid_reg;

endmodule

[hw/rtl/latency_log_histogram_stats_unit.sv]
// Latency statistics top level: counters, histogram controller and percentile walk.
// Record request: latency, two bucket index stages, memory read, write back. No new request is taken
// until the result is handed off. Query request: the top bucket's midpoint on an empty histogram,
// else the midpoint where the walk stops: the first bucket reaching the percentile, else the last.
// The walk reads one bucket per cycle. Reset clears all counters, then a clearing pass zeroes all
// SUB_BUCKETS*OCTAVES buckets (1152 by default) before the first request is taken.
module latency_log_histogram_stats_unit #(
    parameter int SUB_BUCKETS = 64,
    parameter int OCTAVES     = 18,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [llhs_pkg::OP_W-1:0]          operation,
    input  logic [llhs_pkg::TIME_W-1:0]        submit_time,
    input  logic [llhs_pkg::TIME_W-1:0]        complete_time,
    input  logic [llhs_pkg::BYTES_W-1:0]       request_bytes,
    input  logic [llhs_pkg::PCT_W-1:0]         percentile_hundredths,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [llhs_pkg::BKT_OUT_W-1:0]     bucket_index,
    output logic [llhs_pkg::LAT_OUT_W-1:0]     percentile_latency,
    output logic [llhs_pkg::CNT_OUT_W-1:0]     request_count,
    output logic [llhs_pkg::SUM_W-1:0]         lowest_latency,
    output logic [llhs_pkg::SUM_W-1:0]         highest_latency,
    output logic [llhs_pkg::SUM_W-1:0]         latency_sum,
    output logic [llhs_pkg::SUM_W-1:0]         byte_sum
);
    import llhs_pkg::*;

    localparam int NBUCKETS = SUB_BUCKETS * OCTAVES;
    localparam int IDX_W    = $clog2(NBUCKETS);
    localparam int PROD_W   = SUM_W + PCT_W;
    localparam int THR_W    = PCT_W + COUNT_WIDTH;
    localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(NBUCKETS - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

    // Controller state
    logic [ST_W-1:0]        state_reg, state_next;
    logic [IDX_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]       bidx_reg, bidx_next;
    logic [IDX_W-1:0]       mid_idx_reg, mid_idx_next;

    // Accepted request
    logic [OP_W-1:0]        op_reg;
    logic [TIME_W-1:0]      lat_reg;
    logic [BYTES_W-1:0]     bytes_reg;
    logic [PCT_W-1:0]       pct_reg;

    // Running statistics
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [SUM_W-1:0]       min_reg, min_next;
    logic [SUM_W-1:0]       max_reg, max_next;
    logic [SUM_W-1:0]       lat_sum_reg, lat_sum_next;
    logic [SUM_W-1:0]       byte_sum_reg, byte_sum_next;

    // Percentile walk pipeline
    logic [THR_W-1:0]       thr_mul;
    logic [PROD_W-1:0]      thr_reg;
    logic [IDX_W-1:0]       walk_addr_reg;
    logic                   issue_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [SUM_W-1:0]       cum_reg;
    logic                   cum_vld_reg;
    logic [IDX_W-1:0]       cum_idx_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   prod_vld_reg;
    logic [IDX_W-1:0]       prod_idx_reg;
    logic [SUM_W:0]         cum_add;
    logic [SUM_W-1:0]       cum_sat;
    logic                   hit;

    // Result register
    logic                   out_vld_reg, out_vld_next;
    logic [BKT_OUT_W-1:0]   bucket_index_reg;
    logic [LAT_OUT_W-1:0]   percentile_latency_reg;
    logic [CNT_OUT_W-1:0]   request_count_reg;
    logic [SUM_W-1:0]       lowest_latency_reg;
    logic [SUM_W-1:0]       highest_latency_reg;
    logic [SUM_W-1:0]       latency_sum_reg;
    logic [SUM_W-1:0]       byte_sum_out_reg;

    // Memory ports and unit hookups
    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [COUNT_WIDTH-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [IDX_W-1:0]       mem_rd_addr;
    logic [COUNT_WIDTH-1:0] mem_rd_data;
    logic                   bkt_vld;
    logic [IDX_W-1:0]       bkt_idx;
    logic [SUM_W-1:0]       mid_lat;

    logic                   in_acc;
    logic                   out_free;
    logic                   load_out;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_vld_reg || !out_stall;
    assign load_out  = (state_reg == ST_DONE) && out_free;

    llhs_bucket_mem #(
        .DEPTH (NBUCKETS),
        .WIDTH (COUNT_WIDTH),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    llhs_bucket_index #(
        .SUB_BUCKETS (SUB_BUCKETS),
        .OCTAVES     (OCTAVES)
    ) u_bkt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (state_reg == ST_LAT),
        .lat     (lat_reg),
        .out_vld (bkt_vld),
        .idx     (bkt_idx)
    );

    llhs_midpoint #(
        .SUB_BUCKETS (SUB_BUCKETS),
        .OCTAVES     (OCTAVES)
    ) u_mid (
        .clk (clk),
        .idx (mid_idx_reg),
        .mid (mid_lat)
    );

    // Drive memory: clearing pass, bucket write back, bucket and walk reads.
    // A record writes its bucket before any later request can read it, so no forwarding.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = clr_addr_reg;
        mem_wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en = 1'b1;
        end
        else if (state_reg == ST_RMW)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = bidx_reg;
            mem_wr_data = (mem_rd_data == CNT_MAX) ? mem_rd_data
                                                   : mem_rd_data + COUNT_WIDTH'(1);
        end

        mem_rd_en   = 1'b0;
        mem_rd_addr = walk_addr_reg;
        if (state_reg == ST_BKT && bkt_vld)
        begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = bkt_idx;
        end
        else if (state_reg == ST_WALK && issue_reg)
        begin
            mem_rd_en = 1'b1;
        end
    end

    // Accumulate with saturation, test against the threshold
    always_comb
    begin
        cum_add = {1'b0, cum_reg} + (SUM_W + 1)'(mem_rd_data);
        cum_sat = cum_add[SUM_W] ? '1 : cum_add[SUM_W-1:0];
        hit     = (prod_reg >= thr_reg);
        thr_mul = THR_W'(pct_reg) * THR_W'(count_reg);
    end

    // Advance the controller and update statistics
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        bidx_next     = bidx_reg;
        mid_idx_next  = mid_idx_reg;
        count_next    = count_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        lat_sum_next  = lat_sum_reg;
        byte_sum_next = byte_sum_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (operation == OP_QUERY) ? ST_THR : ST_LAT;
                end
            end
            ST_LAT:
            begin
                state_next = ST_BKT;
            end
            ST_BKT:
            begin
                if (bkt_vld)
                begin
                    bidx_next  = bkt_idx;
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                if (count_reg == '0)
                begin
                    min_next = lat_reg;
                    max_next = lat_reg;
                end
                else
                begin
                    if (lat_reg < min_reg)
                    begin
                        min_next = lat_reg;
                    end
                    if (lat_reg > max_reg)
                    begin
                        max_next = lat_reg;
                    end
                end
                lat_sum_next  = lat_sum_reg + lat_reg;
                byte_sum_next = byte_sum_reg + SUM_W'(bytes_reg);
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
                state_next = ST_DONE;
            end
            ST_THR:
            begin
                if (count_reg == '0)
                begin
                    mid_idx_next = LAST_IDX;
                    state_next   = ST_MID;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (prod_vld_reg && (hit || prod_idx_reg == LAST_IDX))
                begin
                    mid_idx_next = prod_idx_reg;
                    state_next   = ST_MID;
                end
            end
            ST_MID:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hand off the result: drop when taken, load when the slot frees
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            lat_sum_reg  <= '0;
            byte_sum_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            lat_sum_reg  <= lat_sum_next;
            byte_sum_reg <= byte_sum_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Walk control: issue one read per cycle, track valid through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_addr_reg <= '0;
            issue_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            cum_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
        end
        else if (state_reg == ST_THR)
        begin
            walk_addr_reg <= '0;
            issue_reg     <= 1'b1;
            rd_vld_reg    <= 1'b0;
            cum_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
        end
        else if (state_reg == ST_WALK)
        begin
            if (issue_reg)
            begin
                walk_addr_reg <= walk_addr_reg + IDX_W'(1);
                if (walk_addr_reg == LAST_IDX)
                begin
                    issue_reg <= 1'b0;
                end
            end
            rd_vld_reg   <= issue_reg;
            cum_vld_reg  <= rd_vld_reg;
            prod_vld_reg <= cum_vld_reg;
        end
        else
        begin
            issue_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            cum_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
    end

    // Walk datapath: cumulative count, scaled product
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_THR)
        begin
            cum_reg <= '0;
            thr_reg <= PROD_W'(thr_mul);
        end
        else if (rd_vld_reg)
        begin
            cum_reg <= cum_sat;
        end
        rd_idx_reg   <= walk_addr_reg;
        cum_idx_reg  <= rd_idx_reg;
        prod_idx_reg <= cum_idx_reg;
        prod_reg     <= PROD_W'(cum_reg) * PROD_W'(PCT_SCALE);
    end

    // Hold the accepted request and the bucket and midpoint indexes
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg    <= operation;
            lat_reg   <= complete_time - submit_time;
            bytes_reg <= request_bytes;
            pct_reg   <= percentile_hundredths;
        end
        bidx_reg    <= bidx_next;
        mid_idx_reg <= mid_idx_next;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (op_reg == OP_QUERY)
            begin
                bucket_index_reg       <= '0;
                percentile_latency_reg <= mid_lat[LAT_OUT_W-1:0];
            end
            else
            begin
                bucket_index_reg       <= BKT_OUT_W'(bidx_reg);
                percentile_latency_reg <= '0;
            end
            request_count_reg   <= CNT_OUT_W'(count_reg);
            lowest_latency_reg  <= min_reg;
            highest_latency_reg <= max_reg;
            latency_sum_reg     <= lat_sum_reg;
            byte_sum_out_reg    <= byte_sum_reg;
        end
    end

    assign out_valid          = out_vld_reg;
    assign bucket_index       = bucket_index_reg;
    assign percentile_latency = percentile_latency_reg;
    assign request_count      = request_count_reg;
    assign lowest_latency     = lowest_latency_reg;
    assign highest_latency    = highest_latency_reg;
    assign latency_sum        = latency_sum_reg;
    assign byte_sum           = byte_sum_out_reg;

endmodule

[tb/latency_log_histogram_stats_unit_tb.sv]
// Self-checking testbench for the latency log-linear histogram statistics unit.
module latency_log_histogram_stats_unit_tb;

    import llhs_pkg::*;

    localparam int HIST_SUBS       = 64;
    localparam int HIST_OCTAVES    = 18;
    localparam int HIST_BUCKETS    = HIST_SUBS * HIST_OCTAVES;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int MAX_SHOWN       = 10;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 1200;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_CYCLIC} stall_mode_t;

    typedef struct packed {
        logic [BKT_OUT_W-1:0] bucket;
        logic [LAT_OUT_W-1:0] pct_lat;
        logic [CNT_OUT_W-1:0] count;
        logic [SUM_W-1:0]     lat_min;
        logic [SUM_W-1:0]     lat_max;
        logic [SUM_W-1:0]     lat_total;
        logic [SUM_W-1:0]     byte_total;
    } stats_t;

    // Track histogram and running statistics, queue the expected stats per request
    class latency_stats_tracker;
        logic [31:0]    hist_count [HIST_BUCKETS];
        logic [31:0]    recorded;
        logic [63:0]    lat_min;
        logic [63:0]    lat_max;
        logic [63:0]    lat_total;
        logic [63:0]    byte_total;
        stats_t         pending_stats [$];
        int unsigned    errors;
        int unsigned    results_seen;

        function new();
            foreach (hist_count[i])
                hist_count[i] = '0;
            recorded     = '0;
            lat_min      = '0;
            lat_max      = '0;
            lat_total    = '0;
            byte_total   = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int unsigned outstanding();
            return pending_stats.size();
        endfunction

        // Halve until below one octave's width; the top octave saturates
        function int unsigned latency_bucket(logic [63:0] lat);
            int unsigned halvings;
            logic [63:0] t;
            logic [63:0] sh;
            t = lat;
            halvings = 0;
            while (t >= HIST_SUBS && halvings < HIST_OCTAVES - 1) begin
                t = t >> 1;
                halvings++;
            end
            if (halvings < 2)
                return int'(lat);
            if (t >= HIST_SUBS)
                return halvings * HIST_SUBS + HIST_SUBS - 1;
            sh = lat >> (halvings - 1);
            return halvings * HIST_SUBS + int'(sh % HIST_SUBS);
        endfunction

        function logic [63:0] bucket_center(int unsigned idx);
            int unsigned oct;
            int unsigned sub;
            oct = idx / HIST_SUBS;
            sub = idx % HIST_SUBS;
            if (oct == 0)
                return 64'(sub);
            return (64'(HIST_SUBS + sub) << (oct - 1)) + ((64'd1 << (oct - 1)) >> 1);
        endfunction

        // Walk buckets until the cumulative share reaches the percentile
        function logic [63:0] find_percentile(logic [PCT_W-1:0] pct);
            logic [127:0] target;
            logic [127:0] scaled;
            logic [63:0]  cum;
            logic [63:0]  nxt;
            int           i;
            if (recorded == 0)
                return bucket_center(HIST_BUCKETS - 1);
            target = 128'(pct) * 128'(recorded);
            cum = '0;
            for (i = 0; i < HIST_BUCKETS; i++) begin
                nxt = cum + 64'(hist_count[i]);
                cum = (nxt < cum) ? '1 : nxt;
                scaled = 128'(cum) * 128'(PCT_SCALE);
                if (scaled >= target)
                    return bucket_center(i);
            end
            return bucket_center(HIST_BUCKETS - 1);
        endfunction

        // Apply one accepted request and queue the stats it must produce
        function void note_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] submit,
                                   logic [TIME_W-1:0] complete,
                                   logic [BYTES_W-1:0] nbytes, logic [PCT_W-1:0] pct);
            stats_t      want;
            logic [63:0] lat;
            logic [63:0] center;
            int unsigned b;
            want = '0;
            if (op == OP_RECORD) begin
                lat = complete - submit;
                b = latency_bucket(lat);
                if (recorded == 0) begin
                    lat_min = lat;
                    lat_max = lat;
                end
                else begin
                    if (lat < lat_min)
                        lat_min = lat;
                    if (lat > lat_max)
                        lat_max = lat;
                end
                lat_total  = lat_total + lat;
                byte_total = byte_total + 64'(nbytes);
                if (recorded != COUNT_MAX)
                    recorded++;
                if (hist_count[b] != COUNT_MAX)
                    hist_count[b]++;
                want.bucket = b[BKT_OUT_W-1:0];
            end
            else begin
                center = find_percentile(pct);
                want.pct_lat = center[LAT_OUT_W-1:0];
            end
            want.count      = recorded;
            want.lat_min    = lat_min;
            want.lat_max    = lat_max;
            want.lat_total  = lat_total;
            want.byte_total = byte_total;
            pending_stats.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("mismatch on %s: expected %0h actual %0h", name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(stats_t got);
            stats_t want;
            results_seen++;
            if (pending_stats.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result: bucket %0d count %0d", got.bucket, got.count);
                return;
            end
            want = pending_stats.pop_front();
            compare_field("bucket_index", 64'(want.bucket), 64'(got.bucket));
            compare_field("percentile_latency", 64'(want.pct_lat), 64'(got.pct_lat));
            compare_field("request_count", 64'(want.count), 64'(got.count));
            compare_field("lowest_latency", want.lat_min, got.lat_min);
            compare_field("highest_latency", want.lat_max, got.lat_max);
            compare_field("latency_sum", want.lat_total, got.lat_total);
            compare_field("byte_sum", want.byte_total, got.byte_total);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation = OP_RECORD;
    logic [TIME_W-1:0]     submit_time = '0;
    logic [TIME_W-1:0]     complete_time = '0;
    logic [BYTES_W-1:0]    request_bytes = '0;
    logic [PCT_W-1:0]      percentile_hundredths = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BKT_OUT_W-1:0]  bucket_index;
    logic [LAT_OUT_W-1:0]  percentile_latency;
    logic [CNT_OUT_W-1:0]  request_count;
    logic [SUM_W-1:0]      lowest_latency;
    logic [SUM_W-1:0]      highest_latency;
    logic [SUM_W-1:0]      latency_sum;
    logic [SUM_W-1:0]      byte_sum;

    latency_stats_tracker  tracker = new();
    int unsigned           burst_left = 0;

    latency_log_histogram_stats_unit DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .operation             (operation),
        .submit_time           (submit_time),
        .complete_time         (complete_time),
        .request_bytes         (request_bytes),
        .percentile_hundredths (percentile_hundredths),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .bucket_index          (bucket_index),
        .percentile_latency    (percentile_latency),
        .request_count         (request_count),
        .lowest_latency        (lowest_latency),
        .highest_latency       (highest_latency),
        .latency_sum           (latency_sum),
        .byte_sum              (byte_sum)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Spread latencies over every octave, boundaries, saturation and full range
    function automatic logic [63:0] pick_latency();
        int unsigned kind;
        int unsigned width;
        logic [63:0] lat;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            width = $urandom_range(0, 24);
            lat = rand64() >> (64 - width);
        end
        else if (kind == 6)
            lat = 64'($urandom_range(0, 127));
        else if (kind == 7) begin
            width = $urandom_range(5, 24);
            lat = (64'd1 << width) + 64'($urandom_range(0, 2)) - 64'd1;
        end
        else if (kind == 8)
            lat = rand64();
        else begin
            width = $urandom_range(24, 63);
            lat = rand64() >> (64 - width);
        end
        return lat;
    endfunction

    // Offer one request, hold it until accepted, then maybe open a gap
    task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] submit,
                                input logic [TIME_W-1:0] complete,
                                input logic [BYTES_W-1:0] nbytes,
                                input logic [PCT_W-1:0] pct);
        int unsigned gap;
        in_valid              <= 1'b1;
        operation             <= op;
        submit_time           <= submit;
        complete_time         <= complete;
        request_bytes         <= nbytes;
        percentile_hundredths <= pct;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(op, submit, complete, nbytes, pct);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_record(input logic [63:0] lat, input logic [BYTES_W-1:0] nbytes);
        logic [63:0] submit;
        submit = rand64();
        send_request(OP_RECORD, submit, submit + lat, nbytes, PCT_W'($urandom));
    endtask

    task automatic send_query(input logic [PCT_W-1:0] pct);
        send_request(OP_QUERY, rand64(), rand64(), BYTES_W'($urandom), pct);
    endtask

    // Pause the sender until every expected result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // Check every accepted result
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({bucket_index, percentile_latency, request_count,
                                  lowest_latency, highest_latency, latency_sum, byte_sum});
    end

    // Stall results on shifting patterns, with one long hold-off
    initial begin
        stall_mode_t mode;
        int unsigned left;
        int unsigned hold_count;
        int unsigned tick;
        bit          held;
        mode = STALL_NONE;
        left = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (!held && tracker.results_seen >= HOLD_AFTER) begin
                out_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge clk);
                    hold_count++;
                end
                held = 1'b1;
            end
            if (left == 0) begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 160);
            end
            left--;
            case (mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((tick % 7) < 3);
            endcase
        end
    end

    // Stimulus: directed corners, then random requests
    initial begin
        int          n;
        logic [PCT_W-1:0] pct;
        logic [BYTES_W-1:0] nbytes;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Query an empty histogram
        send_query(PCT_W'(5000));
        send_query('0);
        // First record wraps around the timestamp range
        send_request(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFCE, 64'd49, '1, '1);
        // Stop at an empty bucket zero, then at the one filled bucket, then miss every bucket
        send_query('0);
        send_query(PCT_W'(PCT_SCALE));
        send_query('1);
        send_request(OP_RECORD, '0, '0, '0, '0);
        send_record(64'd1, 32'd1);
        send_record(64'd63, 32'd100);
        send_record(64'd64, 32'd1000);
        send_record(64'd127, '1);
        send_record(64'd128, 32'd7);
        send_record(64'd255, 32'd9);
        send_record(64'd256, 32'd11);
        send_record(64'h7F_FFFF, 32'h8000_0000);
        send_record(64'h80_0000, 32'd3);
        send_request(OP_RECORD, '0, '1, '1, '0);
        send_query(PCT_W'(1));
        send_query(PCT_W'(5000));
        send_query(PCT_W'(9999));
        send_query(PCT_W'(PCT_SCALE));
        send_query(PCT_W'(PCT_SCALE + 1));
        send_query('1);
        wait_for_results();

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2)
                wait_for_results();
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 9))
                    0:       pct = '0;
                    1:       pct = PCT_W'(PCT_SCALE);
                    2:       pct = PCT_W'($urandom_range(PCT_SCALE + 1, 2 ** PCT_W - 1));
                    default: pct = PCT_W'($urandom_range(0, PCT_SCALE));
                endcase
                send_query(pct);
            end
            else begin
                case ($urandom_range(0, 15))
                    0:       nbytes = '0;
                    1:       nbytes = '1;
                    default: nbytes = BYTES_W'($urandom);
                endcase
                send_record(pick_latency(), nbytes);
            end
        end

        // Drain, let the block settle, then report
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Bound the run
    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
